@@ rtl/four_axis_bresenham_step_generator_top_defines.svh @@
// ============================================================================
// Four-axis step generator assertion macros
// Shared property forms for the checker, clocked on i_clk and held off
// while i_rst_n is low.
// ============================================================================
`ifndef FOUR_AXIS_BRESENHAM_STEP_GENERATOR_TOP_DEFINES_SVH
`define FOUR_AXIS_BRESENHAM_STEP_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FABSG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("%m: property failed");

// The consequent must hold in the cycle after the antecedent.
`define FABSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("%m: property failed");

`endif

@@ rtl/fabsg_pkg.sv @@
// ============================================================================
// Step generator package
// Item kinds, axis count and the control bundle that the sequencer sends
// to each axis.
// ============================================================================
`timescale 1ns / 1ps

package fabsg_pkg;

    localparam int AXES = 4;
    localparam int TARGET_BITS = 32;
    localparam int PERIOD_IN_BITS = 24;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
    } t_axis_ctrl;

endpackage

@@ rtl/fabsg_axis.sv @@
// ============================================================================
// Step generator axis
// Keeps one axis's position, distance, step count and error term. A load
// starts a new move from the kept position; a step event runs one
// Bresenham update and may pulse the axis.
// ============================================================================
`timescale 1ns / 1ps

module fabsg_axis #(
    parameter int POSITION_BITS = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  fabsg_pkg::t_axis_ctrl                      i_ctrl,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0]   i_target,
    input  logic        [POSITION_BITS-1:0]            i_longest,
    input  logic        [POSITION_BITS-1:0]            i_seed,
    output logic        [POSITION_BITS-1:0]            o_mag,
    output logic                                       o_pulse,
    output logic                                       o_left,
    output logic                                       o_reverse
);

    localparam int P = POSITION_BITS;

    logic [P-1:0]        r_pos;
    logic [P-1:0]        r_dist;
    logic [P-1:0]        r_taken;
    logic [P:0]          r_err;
    logic                r_neg;

    logic [P-1:0]        w_tgt;
    logic signed [P:0]   w_diff;
    logic [P:0]          w_mag;
    logic                w_active;
    logic signed [P+1:0] w_err_sub;
    logic signed [P+1:0] w_err_add;
    logic                w_fire;
    logic [P-1:0]        w_taken_inc;

    assign w_tgt  = P'(i_target);
    assign w_diff = $signed({w_tgt[P-1], w_tgt}) - $signed({r_pos[P-1], r_pos});
    assign w_mag  = w_diff[P] ? (~w_diff + (P+1)'(1)) : w_diff;
    assign o_mag  = w_mag[P-1:0];

    assign w_active    = r_taken < r_dist;
    assign w_err_sub   = $signed({r_err[P], r_err}) - $signed({2'b00, r_dist});
    assign w_err_add   = w_err_sub + $signed({2'b00, i_longest});
    assign w_fire      = i_ctrl.step && w_active && w_err_sub[P+1];
    assign w_taken_inc = r_taken + P'(1);

    assign o_pulse   = w_fire;
    assign o_left    = (w_fire ? w_taken_inc : r_taken) < r_dist;
    assign o_reverse = r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_dist  <= '0;
            r_taken <= '0;
            r_err   <= '0;
            r_neg   <= 1'b0;
        end else if (i_ctrl.load) begin
            r_dist  <= w_mag[P-1:0];
            r_neg   <= w_diff[P];
            r_taken <= '0;
            r_err   <= {1'b0, i_seed};
        end else if (i_ctrl.step && w_active) begin
            if (w_fire) begin
                r_err   <= w_err_add[P:0];
                r_taken <= w_taken_inc;
                r_pos   <= r_neg ? (r_pos - P'(1)) : (r_pos + P'(1));
            end else begin
                r_err   <= w_err_sub[P:0];
            end
        end
    end

endmodule

@@ rtl/fabsg_seq.sv @@
// ============================================================================
// Step generator sequencer
// Holds the move status, the step period and the tick count, finds the
// longest axis distance of a new move and decides step events and the end
// of a move.
// ============================================================================
`timescale 1ns / 1ps

module fabsg_seq #(
    parameter int POSITION_BITS = 32,
    parameter int PERIOD_BITS   = 24
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_go,
    input  logic [1:0]                                    i_kind,
    input  logic [fabsg_pkg::PERIOD_IN_BITS-1:0]          i_period,
    input  logic [fabsg_pkg::AXES-1:0][POSITION_BITS-1:0] i_mags,
    input  logic [fabsg_pkg::AXES-1:0]                    i_left,
    output fabsg_pkg::t_axis_ctrl                         o_ctrl,
    output logic [POSITION_BITS-1:0]                      o_longest,
    output logic [POSITION_BITS-1:0]                      o_seed,
    output logic                                          o_busy,
    output logic                                          o_done
);

    logic [POSITION_BITS-1:0] r_longest;
    logic [PERIOD_BITS-1:0]   r_period;
    logic [PERIOD_BITS-1:0]   r_elapsed;
    logic                     r_moving;

    logic [POSITION_BITS-1:0] w_max_lo;
    logic [POSITION_BITS-1:0] w_max_hi;
    logic [POSITION_BITS-1:0] n_longest;
    logic [PERIOD_BITS-1:0]   w_per;
    logic [PERIOD_BITS-1:0]   n_period;
    logic [PERIOD_BITS-1:0]   w_elapsed_inc;
    logic                     w_tick;
    logic                     w_move;
    logic                     w_stop;
    logic                     w_step;

    assign w_max_lo  = (i_mags[1] > i_mags[0]) ? i_mags[1] : i_mags[0];
    assign w_max_hi  = (i_mags[3] > i_mags[2]) ? i_mags[3] : i_mags[2];
    assign n_longest = (w_max_hi > w_max_lo) ? w_max_hi : w_max_lo;

    assign w_per    = PERIOD_BITS'(i_period);
    assign n_period = (w_per == '0) ? PERIOD_BITS'(1) : w_per;

    assign w_tick        = i_go && (i_kind == fabsg_pkg::KIND_TICK) && r_moving;
    assign w_move        = i_go && (i_kind == fabsg_pkg::KIND_MOVE);
    assign w_stop        = i_go && (i_kind == fabsg_pkg::KIND_STOP);
    assign w_elapsed_inc = r_elapsed + PERIOD_BITS'(1);
    assign w_step        = w_tick && (w_elapsed_inc >= r_period);

    assign o_ctrl.load = w_move;
    assign o_ctrl.step = w_step;
    assign o_longest   = r_longest;
    assign o_seed      = n_longest >> 1;
    assign o_busy      = r_moving;
    assign o_done      = w_step && !(|i_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_longest <= '0;
            r_period  <= '0;
            r_elapsed <= '0;
            r_moving  <= 1'b0;
        end else if (w_move) begin
            r_longest <= n_longest;
            r_period  <= n_period;
            r_elapsed <= '0;
            r_moving  <= 1'b1;
        end else if (w_stop) begin
            r_moving  <= 1'b0;
        end else if (w_tick) begin
            r_elapsed <= w_step ? '0 : w_elapsed_inc;
            if (o_done) begin
                r_moving <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/four_axis_bresenham_step_generator_top.sv @@
// Throughput: one item per cycle while results are not held back; each item
// is finished by one pass through the axis update logic between the input
// register and the result register.
// Reset: synchronous, active low; all axes return to position zero, the
// block goes idle and both registers are emptied.
// ============================================================================
// Four-axis Bresenham step generator
// Registers each item, runs it through the sequencer and the four axis
// units and holds the pulses and the done flag in a result register.
// ============================================================================
`timescale 1ns / 1ps

module four_axis_bresenham_step_generator_top #(
    parameter int POSITION_BITS = 32,
    parameter int PERIOD_BITS   = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [1:0]                                 i_kind,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0]   i_x_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0]   i_y_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0]   i_z_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0]   i_e_target,
    input  logic [fabsg_pkg::PERIOD_IN_BITS-1:0]       i_step_period,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic                                       o_x_pulse,
    output logic                                       o_x_reverse,
    output logic                                       o_y_pulse,
    output logic                                       o_y_reverse,
    output logic                                       o_z_pulse,
    output logic                                       o_z_reverse,
    output logic                                       o_e_pulse,
    output logic                                       o_e_reverse,
    output logic                                       o_busy_res,
    output logic                                       o_move_done
);

    localparam int A = fabsg_pkg::AXES;

    logic                                         r_in_valid;
    logic [1:0]                                   r_kind;
    logic [A-1:0][fabsg_pkg::TARGET_BITS-1:0]     r_target;
    logic [fabsg_pkg::PERIOD_IN_BITS-1:0]         r_period;
    logic                                         r_out_valid;
    logic [A-1:0]                                 r_pulse;
    logic                                         r_done;

    logic                                         w_go;
    fabsg_pkg::t_axis_ctrl                        w_ctrl;
    logic [A-1:0][POSITION_BITS-1:0]              w_mags;
    logic [A-1:0]                                 w_pulse;
    logic [A-1:0]                                 w_left;
    logic [A-1:0]                                 w_reverse;
    logic [POSITION_BITS-1:0]                     w_longest;
    logic [POSITION_BITS-1:0]                     w_seed;
    logic                                         w_busy;
    logic                                         w_done;

    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind      <= i_kind;
            r_target[0] <= i_x_target;
            r_target[1] <= i_y_target;
            r_target[2] <= i_z_target;
            r_target[3] <= i_e_target;
            r_period    <= i_step_period;
        end
    end

    fabsg_seq #(
        .POSITION_BITS (POSITION_BITS),
        .PERIOD_BITS   (PERIOD_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (w_go),
        .i_kind    (r_kind),
        .i_period  (r_period),
        .i_mags    (w_mags),
        .i_left    (w_left),
        .o_ctrl    (w_ctrl),
        .o_longest (w_longest),
        .o_seed    (w_seed),
        .o_busy    (w_busy),
        .o_done    (w_done)
    );

    for (genvar g = 0; g < A; g++) begin : g_axis
        fabsg_axis #(
            .POSITION_BITS (POSITION_BITS)
        ) u_axis (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_target  ($signed(r_target[g])),
            .i_longest (w_longest),
            .i_seed    (w_seed),
            .o_mag     (w_mags[g]),
            .o_pulse   (w_pulse[g]),
            .o_left    (w_left[g]),
            .o_reverse (w_reverse[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_pulse <= w_pulse;
            r_done  <= w_done;
        end
    end

    // Direction and busy come straight from state, which only changes when
    // a new result is loaded.
    assign o_out_valid = r_out_valid;
    assign o_x_pulse   = r_pulse[0];
    assign o_y_pulse   = r_pulse[1];
    assign o_z_pulse   = r_pulse[2];
    assign o_e_pulse   = r_pulse[3];
    assign o_x_reverse = w_reverse[0];
    assign o_y_reverse = w_reverse[1];
    assign o_z_reverse = w_reverse[2];
    assign o_e_reverse = w_reverse[3];
    assign o_busy_res  = w_busy;
    assign o_move_done = r_done;

endmodule

@@ rtl/fabsg_checker.sv @@
// ============================================================================
// Step generator checker
// Watches the top level's ports for flow control and result consistency.
// ============================================================================
`timescale 1ns / 1ps
`include "four_axis_bresenham_step_generator_top_defines.svh"

module fabsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_kind,
    input logic [31:0] i_x_target,
    input logic [31:0] i_y_target,
    input logic [31:0] i_z_target,
    input logic [31:0] i_e_target,
    input logic [23:0] i_step_period,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_x_pulse,
    input logic        o_x_reverse,
    input logic        o_y_pulse,
    input logic        o_y_reverse,
    input logic        o_z_pulse,
    input logic        o_z_reverse,
    input logic        o_e_pulse,
    input logic        o_e_reverse,
    input logic        o_busy_res,
    input logic        o_move_done
);

    // The input side only stalls when a finished result is held back.
    `FABSG_ASSERT_SAME(a_ready_stall, !o_in_ready, o_out_valid && !i_out_ready)

    // A completed move leaves the block idle.
    `FABSG_ASSERT_SAME(a_done_idle, o_out_valid && o_move_done, !o_busy_res)

    // A pulse only comes from a move that is running or just finished.
    `FABSG_ASSERT_SAME(a_pulse_moving,
        o_out_valid && (o_x_pulse || o_y_pulse || o_z_pulse || o_e_pulse),
        o_busy_res || o_move_done)

    // A waiting input transaction keeps its payload.
    `FABSG_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready,
        i_in_valid && $stable(i_kind) && $stable(i_x_target) && $stable(i_y_target) &&
        $stable(i_z_target) && $stable(i_e_target) && $stable(i_step_period))

    // A held result keeps its transaction intact.
    `FABSG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_x_pulse) && $stable(o_x_reverse) &&
        $stable(o_y_pulse) && $stable(o_y_reverse) &&
        $stable(o_z_pulse) && $stable(o_z_reverse) &&
        $stable(o_e_pulse) && $stable(o_e_reverse) &&
        $stable(o_busy_res) && $stable(o_move_done))

endmodule

bind four_axis_bresenham_step_generator_top fabsg_checker u_fabsg_checker (.*);

@@ tb/four_axis_bresenham_step_generator_checker.sv @@
// ============================================================================
// Four-axis step generator checker
// Watches both channels of the step generator. It keeps its own copy of the
// axis positions, distances and error terms, works out the pulses and status
// for every accepted input transaction, and compares each accepted result,
// field by field, with the oldest expected one.
// ============================================================================
`timescale 1ns / 1ps

module four_axis_bresenham_step_generator_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0] i_x_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0] i_y_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0] i_z_target,
    input  logic signed [fabsg_pkg::TARGET_BITS-1:0] i_e_target,
    input  logic [fabsg_pkg::PERIOD_IN_BITS-1:0]     i_step_period,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_x_pulse,
    input  logic                                i_x_reverse,
    input  logic                                i_y_pulse,
    input  logic                                i_y_reverse,
    input  logic                                i_z_pulse,
    input  logic                                i_z_reverse,
    input  logic                                i_e_pulse,
    input  logic                                i_e_reverse,
    input  logic                                i_busy_res,
    input  logic                                i_move_done,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic x_pulse;
        logic x_reverse;
        logic y_pulse;
        logic y_reverse;
        logic z_pulse;
        logic z_reverse;
        logic e_pulse;
        logic e_reverse;
        logic busy_res;
        logic move_done;
    } t_step_result;

    typedef logic signed [fabsg_pkg::TARGET_BITS-1:0] t_target_set [fabsg_pkg::AXES];

    localparam int RESULT_BITS = $bits(t_step_result);

    logic signed [fabsg_pkg::TARGET_BITS-1:0] kept_pos [fabsg_pkg::AXES];
    logic [fabsg_pkg::TARGET_BITS-1:0]        travel [fabsg_pkg::AXES];
    logic [fabsg_pkg::TARGET_BITS-1:0]        taken [fabsg_pkg::AXES];
    logic signed [fabsg_pkg::TARGET_BITS:0]   error_term [fabsg_pkg::AXES];
    logic                                     reverse [fabsg_pkg::AXES];
    logic [fabsg_pkg::TARGET_BITS-1:0]        longest;
    logic [fabsg_pkg::PERIOD_IN_BITS-1:0]     event_period;
    logic [fabsg_pkg::PERIOD_IN_BITS-1:0]     tick_count;
    logic                                     moving;

    t_step_result step_results_q [$];
    string        field_label [RESULT_BITS];
    int           mismatches = 0;
    int           awaiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = awaiting;

    initial begin
        field_label = '{"x_pulse", "x_reverse", "y_pulse", "y_reverse", "z_pulse",
                        "z_reverse", "e_pulse", "e_reverse", "busy_res", "move_done"};
    end

    function automatic t_step_result advance_axes(
        input logic [1:0] kind,
        input t_target_set target,
        input logic [fabsg_pkg::PERIOD_IN_BITS-1:0] period);
        t_step_result                res;
        logic [fabsg_pkg::AXES-1:0]  pulse;
        longint                      diff;
        longint                      err;
        logic                        all_done;
        int                          a;
        res      = '0;
        pulse    = '0;
        all_done = 1'b1;
        case (kind)
            fabsg_pkg::KIND_MOVE: begin
                longest = '0;
                for (a = 0; a < fabsg_pkg::AXES; a++) begin
                    diff       = longint'(target[a]) - longint'(kept_pos[a]);
                    reverse[a] = (diff < 0);
                    travel[a]  = (diff < 0) ? fabsg_pkg::TARGET_BITS'(-diff) :
                                              fabsg_pkg::TARGET_BITS'(diff);
                    taken[a]   = '0;
                    if (travel[a] > longest) begin
                        longest = travel[a];
                    end
                end
                for (a = 0; a < fabsg_pkg::AXES; a++) begin
                    error_term[a] = $signed({2'b00, longest[fabsg_pkg::TARGET_BITS-1:1]});
                end
                event_period = (period == '0) ? fabsg_pkg::PERIOD_IN_BITS'(1) : period;
                tick_count   = '0;
                moving       = 1'b1;
            end
            fabsg_pkg::KIND_STOP: begin
                moving = 1'b0;
            end
            fabsg_pkg::KIND_TICK: begin
                if (moving) begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= event_period) begin
                        tick_count = '0;
                        for (a = 0; a < fabsg_pkg::AXES; a++) begin
                            if (taken[a] < travel[a]) begin
                                err = longint'(error_term[a]) - longint'(travel[a]);
                                if (err < 0) begin
                                    pulse[a]    = 1'b1;
                                    err         = err + longint'(longest);
                                    taken[a]    = taken[a] + 1'b1;
                                    kept_pos[a] = reverse[a] ? kept_pos[a] - 1 :
                                                               kept_pos[a] + 1;
                                end
                                error_term[a] = err[fabsg_pkg::TARGET_BITS:0];
                            end
                            if (taken[a] < travel[a]) begin
                                all_done = 1'b0;
                            end
                        end
                        if (all_done) begin
                            moving        = 1'b0;
                            res.move_done = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.x_pulse   = pulse[0];
        res.x_reverse = reverse[0];
        res.y_pulse   = pulse[1];
        res.y_reverse = reverse[1];
        res.z_pulse   = pulse[2];
        res.z_reverse = reverse[2];
        res.e_pulse   = pulse[3];
        res.e_reverse = reverse[3];
        res.busy_res  = moving;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_target_set  target;
        t_step_result seen;
        t_step_result want;
        int           a;
        int           f;
        if (!i_rst_n) begin
            for (a = 0; a < fabsg_pkg::AXES; a++) begin
                kept_pos[a]   = '0;
                travel[a]     = '0;
                taken[a]      = '0;
                error_term[a] = '0;
                reverse[a]    = 1'b0;
            end
            longest      = '0;
            event_period = '0;
            tick_count   = '0;
            moving       = 1'b0;
            step_results_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                target = '{i_x_target, i_y_target, i_z_target, i_e_target};
                step_results_q.push_back(advance_axes(i_kind, target, i_step_period));
            end
            if (i_out_valid && i_out_ready) begin
                seen = '{i_x_pulse, i_x_reverse, i_y_pulse, i_y_reverse, i_z_pulse,
                         i_z_reverse, i_e_pulse, i_e_reverse, i_busy_res, i_move_done};
                if (step_results_q.size() == 0) begin
                    $display("%0t: result with no transaction pending, expected none, got %b",
                             $time, seen);
                    mismatches++;
                end else begin
                    want = step_results_q.pop_front();
                    for (f = 0; f < RESULT_BITS; f++) begin
                        if (want[RESULT_BITS-1-f] !== seen[RESULT_BITS-1-f]) begin
                            $display("%0t: %s mismatch, expected %b, got %b", $time,
                                     field_label[f], want[RESULT_BITS-1-f],
                                     seen[RESULT_BITS-1-f]);
                            mismatches++;
                        end
                    end
                end
            end
        end
        awaiting = step_results_q.size();
    end

endmodule

@@ tb/four_axis_bresenham_step_generator_top_tb.sv @@
// ============================================================================
// Four-axis step generator testbench
// Drives move, stop and tick transactions into the step generator, first a
// directed set covering the extremes and corner cases, then random move
// sequences under three idling patterns. A separate checker predicts and
// compares every result; this module only makes stimulus and gives the
// verdict.
// ============================================================================
`timescale 1ns / 1ps

module four_axis_bresenham_step_generator_top_tb;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PHASE_ITEMS  = 700;
    localparam int         DRAIN_CYCLES = 8;

    logic                                     clk = 1'b0;
    logic                                     rst_n = 1'b0;
    logic                                     in_valid = 1'b0;
    logic                                     in_ready;
    logic [1:0]                               kind = fabsg_pkg::KIND_TICK;
    logic signed [fabsg_pkg::TARGET_BITS-1:0] x_target = '0;
    logic signed [fabsg_pkg::TARGET_BITS-1:0] y_target = '0;
    logic signed [fabsg_pkg::TARGET_BITS-1:0] z_target = '0;
    logic signed [fabsg_pkg::TARGET_BITS-1:0] e_target = '0;
    logic [fabsg_pkg::PERIOD_IN_BITS-1:0]     step_period = '0;
    logic                                     out_valid;
    logic                                     out_ready = 1'b0;
    logic                                     x_pulse;
    logic                                     x_reverse;
    logic                                     y_pulse;
    logic                                     y_reverse;
    logic                                     z_pulse;
    logic                                     z_reverse;
    logic                                     e_pulse;
    logic                                     e_reverse;
    logic                                     busy_res;
    logic                                     move_done;
    int                                       fail_count;
    int                                       pending;
    int                                       send_gap_pct = 0;
    int                                       sink_stall_pct = 0;
    int                                       items_left = 0;
    int                                       cycle_count = 0;

    four_axis_bresenham_step_generator_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (kind),
        .i_x_target   (x_target),
        .i_y_target   (y_target),
        .i_z_target   (z_target),
        .i_e_target   (e_target),
        .i_step_period(step_period),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_x_pulse    (x_pulse),
        .o_x_reverse  (x_reverse),
        .o_y_pulse    (y_pulse),
        .o_y_reverse  (y_reverse),
        .o_z_pulse    (z_pulse),
        .o_z_reverse  (z_reverse),
        .o_e_pulse    (e_pulse),
        .o_e_reverse  (e_reverse),
        .o_busy_res   (busy_res),
        .o_move_done  (move_done)
    );

    four_axis_bresenham_step_generator_checker step_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_kind       (kind),
        .i_x_target   (x_target),
        .i_y_target   (y_target),
        .i_z_target   (z_target),
        .i_e_target   (e_target),
        .i_step_period(step_period),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_x_pulse    (x_pulse),
        .i_x_reverse  (x_reverse),
        .i_y_pulse    (y_pulse),
        .i_y_reverse  (y_reverse),
        .i_z_pulse    (z_pulse),
        .i_z_reverse  (z_reverse),
        .i_e_pulse    (e_pulse),
        .i_e_reverse  (e_reverse),
        .i_busy_res   (busy_res),
        .i_move_done  (move_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] k,
                             input logic signed [fabsg_pkg::TARGET_BITS-1:0] x,
                             input logic signed [fabsg_pkg::TARGET_BITS-1:0] y,
                             input logic signed [fabsg_pkg::TARGET_BITS-1:0] z,
                             input logic signed [fabsg_pkg::TARGET_BITS-1:0] e,
                             input logic [fabsg_pkg::PERIOD_IN_BITS-1:0] period);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        x_target    <= x;
        y_target    <= y;
        z_target    <= z;
        e_target    <= e;
        step_period <= period;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        items_left--;
    endtask

    task automatic send_noise(input logic [1:0] k);
        send_item(k, $urandom, $urandom, $urandom, $urandom,
                  fabsg_pkg::PERIOD_IN_BITS'($urandom));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [fabsg_pkg::TARGET_BITS-1:0] near_origin();
        return $urandom_range(0, 48) - 24;
    endfunction

    task automatic run_random_phase(input int budget);
        int choice;
        int burst;
        int n;
        items_left = budget;
        while (items_left > 0) begin
            choice = $urandom_range(0, 99);
            if (choice < 70) begin
                send_item(fabsg_pkg::KIND_MOVE, near_origin(), near_origin(), near_origin(),
                          near_origin(), fabsg_pkg::PERIOD_IN_BITS'($urandom_range(0, 3)));
                burst = $urandom_range(1, 60);
            end else if (choice < 82) begin
                send_item(fabsg_pkg::KIND_MOVE, $urandom, $urandom, $urandom, $urandom,
                          fabsg_pkg::PERIOD_IN_BITS'(($urandom_range(0, 1) == 0) ?
                              $urandom : $urandom_range(0, 3)));
                burst = $urandom_range(1, 20);
            end else begin
                burst = $urandom_range(1, 10);
            end
            for (n = 0; n < burst; n++) begin
                choice = $urandom_range(0, 99);
                if (choice < 2) begin
                    send_noise(fabsg_pkg::KIND_STOP);
                end else if (choice < 4) begin
                    send_noise(KIND_UNUSED);
                end else begin
                    send_noise(fabsg_pkg::KIND_TICK);
                end
            end
        end
    endtask

    initial begin
        int n;
        send_gap_pct   = 31;
        sink_stall_pct = 80;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_noise(fabsg_pkg::KIND_TICK);
        send_noise(KIND_UNUSED);
        send_noise(fabsg_pkg::KIND_STOP);
        send_item(fabsg_pkg::KIND_MOVE, 5, -3, 0, 2, 24'd0);
        for (n = 0; n < 6; n++) begin
            send_noise(fabsg_pkg::KIND_TICK);
        end
        send_item(fabsg_pkg::KIND_MOVE, 5, -3, 0, 2, 24'd1);
        send_noise(fabsg_pkg::KIND_TICK);
        send_item(fabsg_pkg::KIND_MOVE, -2, 4, 7, -6, 24'd3);
        for (n = 0; n < 5; n++) begin
            send_noise(fabsg_pkg::KIND_TICK);
        end
        send_item(fabsg_pkg::KIND_MOVE, 0, 0, 0, 0, 24'd2);
        send_noise(fabsg_pkg::KIND_TICK);
        send_noise(fabsg_pkg::KIND_TICK);
        send_noise(KIND_UNUSED);
        send_noise(fabsg_pkg::KIND_STOP);
        send_noise(fabsg_pkg::KIND_TICK);
        send_item(fabsg_pkg::KIND_MOVE, 32'sh7fffffff, 32'sh80000000, -1, 1, 24'hffffff);
        send_noise(fabsg_pkg::KIND_TICK);
        send_item(fabsg_pkg::KIND_MOVE, 32'sh80000000, 32'sh7fffffff, 1, -1, 24'd1);
        send_noise(fabsg_pkg::KIND_TICK);
        send_noise(fabsg_pkg::KIND_STOP);

        run_random_phase(PHASE_ITEMS);
        wait_for_results();

        send_gap_pct   = 80;
        sink_stall_pct = 31;
        run_random_phase(PHASE_ITEMS);
        wait_for_results();

        send_gap_pct   = 0;
        sink_stall_pct = 0;
        run_random_phase(PHASE_ITEMS);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
